// ===== rtl/core/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the 2x2 box-filter mip downsampler
// Holds the payload structs of both streams, the register map and the
// configuration bundle passed from the register block to the datapath.
// ----------------------------------------------------------------------------
package bfm_pkg;

    // Largest source height the row counter covers.
    localparam int MAX_HEIGHT = 4096;

    // Number of component lanes carried on the ports.
    localparam int PORT_LANES = 4;

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_COMPONENT_COUNT = 2'd2;

    // Reset values of the registers.
    localparam logic [12:0] RESET_IMAGE_WIDTH     = 13'd4;
    localparam logic [12:0] RESET_IMAGE_HEIGHT    = 13'd4;
    localparam logic [2:0]  RESET_COMPONENT_COUNT = 3'd4;

    // One source texel.
    typedef struct packed {
        logic [7:0] texel_c0;
        logic [7:0] texel_c1;
        logic [7:0] texel_c2;
        logic [7:0] texel_c3;
    } texel_t;

    // One averaged output texel.
    typedef struct packed {
        logic [7:0] mip_c0;
        logic [7:0] mip_c1;
        logic [7:0] mip_c2;
        logic [7:0] mip_c3;
        logic       level_end;
    } mip_t;

    // Current register contents.
    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  component_count;
    } cfg_t;

    // Per-lane sums of a horizontal pair of texels.
    typedef logic [PORT_LANES-1:0][8:0] pair_vec_t;

    // Work handed from the pair stage to the averaging stage.
    typedef struct packed {
        pair_vec_t pair;
        logic      from_line;
        logic      level_end;
    } avg_req_t;

endpackage

// ===== rtl/core/bfm_regs.sv =====
// ----------------------------------------------------------------------------
// bfm_regs: configuration registers
// APB-style register file for width, height and component count. A write to
// a valid register also issues a restart pulse that rewinds the level.
// ----------------------------------------------------------------------------
module bfm_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bfm_pkg::cfg_t      cfg,
    output logic               restart
);
    import bfm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic write_en;
    logic hit;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;

    // Decode the write and form the next register contents.
    always_comb
    begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (write_en)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:
                begin
                    cfg_next.image_width = pwdata[12:0];
                    hit = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    cfg_next.image_height = pwdata[12:0];
                    hit = 1'b1;
                end
                REG_COMPONENT_COUNT:
                begin
                    cfg_next.component_count = pwdata[2:0];
                    hit = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= RESET_IMAGE_WIDTH;
            cfg_reg.image_height    <= RESET_IMAGE_HEIGHT;
            cfg_reg.component_count <= RESET_COMPONENT_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:     prdata = {19'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT:    prdata = {19'd0, cfg_reg.image_height};
            REG_COMPONENT_COUNT: prdata = {29'd0, cfg_reg.component_count};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg     = cfg_reg;
    assign restart = hit;

endmodule

// ===== rtl/core/bfm_line_buf.sv =====
// ----------------------------------------------------------------------------
// bfm_line_buf: pair-sum line buffer
// Simple dual-port memory holding the horizontal pair sums of the row above,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfm_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 36
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bfm_avg.sv =====
// ----------------------------------------------------------------------------
// bfm_avg: vertical sum, average and output register
// Adds the current pair sum to the stored pair sum of the row above (or to
// itself at height 1), takes the truncated quarter per lane and outputs it.
// ----------------------------------------------------------------------------
module bfm_avg #(
    parameter int LANES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  load_valid,
    input  bfm_pkg::avg_req_t     load_req,
    input  logic [LANES*9-1:0]    line_data,
    input  logic [2:0]            component_count,
    output logic                  ready,
    output logic                  mip_valid,
    input  logic                  mip_stall,
    output bfm_pkg::mip_t         mip_texel
);
    import bfm_pkg::*;

    logic     req_valid_reg;
    avg_req_t req_reg;
    logic     out_valid_reg;
    mip_t     out_reg;
    mip_t     out_next;
    logic     advance;
    logic [PORT_LANES-1:0][7:0] lane_avg;
    pair_vec_t above;

    // The output register moves whenever it is empty or being taken.
    assign advance = !out_valid_reg || !mip_stall;
    assign ready   = !req_valid_reg || advance;

    // Unpack the line buffer word into lanes.
    always_comb
    begin
        above = '0;
        for (int i = 0; i < LANES; i++)
        begin
            above[i] = line_data[i*9 +: 9];
        end
    end

    // Vertical sum and truncated average, masked by the component count.
    always_comb
    begin
        logic [9:0] sum;
        for (int i = 0; i < PORT_LANES; i++)
        begin
            if (req_reg.from_line)
            begin
                sum = {1'b0, above[i]} + {1'b0, req_reg.pair[i]};
            end
            else
            begin
                sum = {req_reg.pair[i], 1'b0};
            end
            if ((i < LANES) && (3'(i) < component_count))
            begin
                lane_avg[i] = sum[9:2];
            end
            else
            begin
                lane_avg[i] = 8'd0;
            end
        end
        out_next.mip_c0    = lane_avg[0];
        out_next.mip_c1    = lane_avg[1];
        out_next.mip_c2    = lane_avg[2];
        out_next.mip_c3    = lane_avg[3];
        out_next.level_end = req_reg.level_end;
    end

    // Valid bits of the request and output stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                req_valid_reg <= load_valid;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= req_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= load_req;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign mip_valid = out_valid_reg;
    assign mip_texel = out_reg;

endmodule

// ===== rtl/core/box_filter_mip_downsample.sv =====
// ----------------------------------------------------------------------------
// box_filter_mip_downsample: 2x2 box-filter mipmap downsampler
// Streams source texels in raster order and produces the next mip level.
//
// The block takes one source texel per clock cycle while src_stall is low,
// and src_stall rises only behind a stalled result. An accepted texel passes
// through the request register to the output register. The line buffer
// takes one write per texel pair on even rows and one read per pair on
// odd rows. Each output is (a+b+c+d)>>2 per component; lanes at or above the
// component count read as zero. An odd last column or row is consumed and
// dropped, and a dimension of 1 pairs a texel with itself. level_end marks
// the final output texel. A write to a valid register rewinds to the first
// texel of a level; the line buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module box_filter_mip_downsample #(
    parameter int MAX_WIDTH = 4096,
    parameter int LANES     = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  bfm_pkg::texel_t    src_texel,
    output logic               mip_valid,
    input  logic               mip_stall,
    output bfm_pkg::mip_t      mip_texel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bfm_pkg::*;

    localparam int PAIR_DEPTH = MAX_WIDTH / 2;
    localparam int AW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int DW = LANES * 9;

    cfg_t cfg;
    logic restart;
    logic avg_ready;
    logic accept;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [11:0]   row_reg;
    logic [11:0]   row_next;
    logic [PORT_LANES-1:0][7:0] left_reg;
    logic [PORT_LANES-1:0][7:0] cur;

    logic [12:0]   w_raw;
    logic [WW-1:0] w_eff;
    logic [12:0]   h_raw;
    logic [12:0]   h_eff;
    logic          w1;
    logic          h1;
    logic          col_last;
    logic          row_last;
    logic          have_pair;
    logic          emit;
    logic          line_wr;
    logic          line_rd;
    logic [CW-1:0] col_half;
    logic [AW-1:0] pair_addr;
    logic [WW-1:0] out_width;
    logic [WW-1:0] pair_col;
    logic [12:0]   last_row;
    pair_vec_t     pair;
    logic [DW-1:0] line_wr_data;
    logic [DW-1:0] line_rd_data;
    avg_req_t      req;

    bfm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    // Effective dimensions: zero counts as one, then saturate.
    always_comb
    begin
        w_raw = (cfg.image_width == 13'd0) ? 13'd1 : cfg.image_width;
        if (32'(w_raw) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(w_raw);
        end
        h_raw = (cfg.image_height == 13'd0) ? 13'd1 : cfg.image_height;
        if (h_raw > 13'(MAX_HEIGHT))
        begin
            h_eff = 13'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_raw;
        end
    end

    assign w1 = (w_eff == WW'(1));
    assign h1 = (h_eff == 13'd1);

    assign src_stall = !avg_ready;
    assign accept    = src_valid && avg_ready;

    assign cur[0] = src_texel.texel_c0;
    assign cur[1] = src_texel.texel_c1;
    assign cur[2] = src_texel.texel_c2;
    assign cur[3] = src_texel.texel_c3;

    // Horizontal pair sum for each lane in use.
    always_comb
    begin
        pair = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (w1)
            begin
                pair[i] = {cur[i], 1'b0};
            end
            else
            begin
                pair[i] = {1'b0, left_reg[i]} + {1'b0, cur[i]};
            end
        end
    end

    // Position decode and line buffer control.
    always_comb
    begin
        have_pair = w1 || col_reg[0];
        emit      = have_pair && (h1 || row_reg[0]);
        line_wr   = accept && have_pair && !h1 && !row_reg[0];
        line_rd   = accept && emit && !h1;
        col_half  = col_reg >> 1;
        pair_addr = col_half[AW-1:0];
        col_last  = (WW'(col_reg) == (w_eff - WW'(1)));
        row_last  = ({1'b0, row_reg} == (h_eff - 13'd1));
        out_width = w1 ? WW'(1) : (w_eff >> 1);
        pair_col  = w1 ? '0 : (WW'(col_reg) >> 1);
        last_row  = h1 ? 13'd0 : ((h_eff & ~13'd1) - 13'd1);
    end

    // Request for the averaging stage.
    always_comb
    begin
        req.pair      = pair;
        req.from_line = !h1;
        req.level_end = (pair_col == (out_width - WW'(1))) &&
                        ({1'b0, row_reg} == last_row);
    end

    // Pack the pair sums for the line buffer.
    always_comb
    begin
        line_wr_data = '0;
        for (int i = 0; i < LANES; i++)
        begin
            line_wr_data[i*9 +: 9] = pair[i];
        end
    end

    // Raster position, advanced per accepted texel.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? 12'd0 : (row_reg + 12'd1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Left texel of the current horizontal pair.
    always_ff @(posedge clk)
    begin
        if (accept && !have_pair)
        begin
            left_reg <= cur;
        end
    end

    bfm_line_buf #(
        .DEPTH (PAIR_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (pair_addr),
        .wr_data (line_wr_data),
        .rd_en   (line_rd),
        .rd_addr (pair_addr),
        .rd_data (line_rd_data)
    );

    bfm_avg #(
        .LANES (LANES)
    ) u_avg (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (accept),
        .load_valid      (emit),
        .load_req        (req),
        .line_data       (line_rd_data),
        .component_count (cfg.component_count),
        .ready           (avg_ready),
        .mip_valid       (mip_valid),
        .mip_stall       (mip_stall),
        .mip_texel       (mip_texel)
    );

endmodule

// ===== rtl/core/bfm_checker.sv =====
// ----------------------------------------------------------------------------
// bfm_checker: port-level assertions for the mip downsampler
// Watches the stream and register ports of the top level and is attached to
// it by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module bfm_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            src_stall,
    input  logic            mip_valid,
    input  logic            mip_stall,
    input  bfm_pkg::mip_t   mip_texel,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata
);
    import bfm_pkg::*;

    logic [2:0] count_reg;

    // Shadow of the component count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RESET_COMPONENT_COUNT;
        end
        else if (psel && penable && pwrite && (paddr[3:2] == REG_COMPONENT_COUNT))
        begin
            count_reg <= pwdata[2:0];
        end
    end

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid && mip_stall |=> mip_valid)
    else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid && mip_stall |=> $stable(mip_texel))
    else $error("result changed while stalled");

    // The input side only stalls behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> mip_valid && mip_stall)
    else $error("input stalled with the output free");

    // Lanes beyond the component count are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid |-> ((count_reg != 3'd0) || (mip_texel.mip_c0 == 8'd0)) &&
                      ((count_reg > 3'd1) || (mip_texel.mip_c1 == 8'd0)) &&
                      ((count_reg > 3'd2) || (mip_texel.mip_c2 == 8'd0)) &&
                      ((count_reg > 3'd3) || (mip_texel.mip_c3 == 8'd0)))
    else $error("unused lane is not zero");

endmodule

bind box_filter_mip_downsample bfm_checker u_bfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_stall (src_stall),
    .mip_valid (mip_valid),
    .mip_stall (mip_stall),
    .mip_texel (mip_texel),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata)
);
